// File: design/pulse_threshold_tdc_peak_adc_defines.svh
// Assertion macros used by the checker file.
`ifndef PULSE_THRESHOLD_TDC_PEAK_ADC_DEFINES_SVH
`define PULSE_THRESHOLD_TDC_PEAK_ADC_DEFINES_SVH

// Check a property outside of reset.
`define PTPA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PTPA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ptpa_pkg.sv
package ptpa_pkg;

    localparam int MAX_SAMPLES_DEFAULT = 256;

    localparam int CELL_W   = 64;
    localparam int TIME_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 15;
    localparam int ADC_W    = 15;
    localparam int PER_W    = 20;
    localparam int TDC_W    = 16;
    localparam int CODE_W   = 31;
    localparam int AMP_W    = 16;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ADC_LIMIT = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD    = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TDC       = 8'd3;

    localparam logic [THR_W-1:0] THR_RESET = 15'd100;
    localparam logic [ADC_W-1:0] ADC_RESET = 15'd1023;
    localparam logic [PER_W-1:0] PER_RESET = 20'd25000;
    localparam logic [TDC_W-1:0] TDC_RESET = 16'd1024;

    localparam int PS_PER_NS = 1000;
    localparam int NUM_W     = 42;
    localparam int DEN_W     = 30;
    localparam int QUO_W     = 32;
    localparam int PROD_W    = QUO_W + TDC_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [CODE_W-1:0] TIME_CODE_MAX = 31'd2147483646;

    typedef struct packed {
        logic sample_en;
        logic snap_en;
        logic mul_en;
        logic div_step;
        logic prod_en;
        logic out_load;
    } ptpa_cmd_t;

    typedef struct packed {
        logic crossing_any;
    } ptpa_status_t;

endpackage

// File: design/pulse_threshold_tdc_peak_adc.sv
// Leading-edge discriminator with peak ADC. Samples of one pulse stream in, one
// per cycle, with s_last on the final one; the block keeps the first sample of
// largest magnitude and the last bin where the pulse falls through minus the
// threshold. A last sample with a crossing yields one hit (cell id, clipped
// negated peak, bin plus whole readout cycles times tdc_per_cycle, saturated);
// without a crossing it yields nothing. Samples are taken at one per cycle
// while s_ready is high. After a last sample that yields a hit, s_ready stays
// low through the 1000x multiply, the restoring divider that finds the cycle
// count (one quotient bit per cycle), the tdc multiply and the load of the
// output register; the load waits while the sink still holds that register.
// Configuration writes are always taken (cfg_ready is high); the user must make them only while idle (not enforced).
module pulse_threshold_tdc_peak_adc #(
    parameter int MAX_SAMPLES = ptpa_pkg::MAX_SAMPLES_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ptpa_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  logic [ptpa_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ptpa_pkg::CELL_W-1:0]           s_cell_id,
    input  logic [ptpa_pkg::TIME_W-1:0]           s_pulse_time_ps,
    input  logic signed [ptpa_pkg::SAMPLE_W-1:0]  s_sample,
    input  logic                                  s_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ptpa_pkg::CELL_W-1:0]           m_hit_cell_id,
    output logic signed [ptpa_pkg::AMP_W-1:0]     m_amplitude,
    output logic [ptpa_pkg::CODE_W-1:0]           m_time_code
);
    import ptpa_pkg::*;

    ptpa_cmd_t    cmd;
    ptpa_status_t status;

    assign cfg_ready = 1'b1;

    ptpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ptpa_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_cell_id       (s_cell_id),
        .s_pulse_time_ps (s_pulse_time_ps),
        .s_sample        (s_sample),
        .s_last          (s_last),
        .cmd             (cmd),
        .status          (status),
        .m_hit_cell_id   (m_hit_cell_id),
        .m_amplitude     (m_amplitude),
        .m_time_code     (m_time_code)
    );

endmodule

// File: design/ptpa_ctrl.sv
module ptpa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_last,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  ptpa_pkg::ptpa_status_t status,
    output ptpa_pkg::ptpa_cmd_t    cmd
);
    import ptpa_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_PROD = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

    state_t                state_reg, state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.sample_en = accept;
        cmd.snap_en   = accept && s_last && status.crossing_any;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.snap_en) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                cmd.prod_en = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: design/ptpa_datapath.sv
module ptpa_datapath #(
    parameter int MAX_SAMPLES = ptpa_pkg::MAX_SAMPLES_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [ptpa_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  logic [ptpa_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [ptpa_pkg::CELL_W-1:0]           s_cell_id,
    input  logic [ptpa_pkg::TIME_W-1:0]           s_pulse_time_ps,
    input  logic signed [ptpa_pkg::SAMPLE_W-1:0]  s_sample,
    input  logic                                  s_last,
    input  ptpa_pkg::ptpa_cmd_t                   cmd,
    output ptpa_pkg::ptpa_status_t                status,
    output logic [ptpa_pkg::CELL_W-1:0]           m_hit_cell_id,
    output logic signed [ptpa_pkg::AMP_W-1:0]     m_amplitude,
    output logic [ptpa_pkg::CODE_W-1:0]           m_time_code
);
    import ptpa_pkg::*;

    localparam int BIN_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [BIN_W-1:0] BIN_HOLD = BIN_W'(MAX_SAMPLES - 1);

    logic [THR_W-1:0] thr_reg;
    logic [ADC_W-1:0] adc_reg;
    logic [PER_W-1:0] per_reg;
    logic [TDC_W-1:0] tdc_reg;

    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [SAMPLE_W-1:0] peak_reg;
    logic [BIN_W-1:0]           bin_reg;
    logic                       seen_reg;
    logic [BIN_W-1:0]           cross_bin_reg;

    logic [CELL_W-1:0]          snap_cell_reg;
    logic [TIME_W-1:0]          snap_time_reg;
    logic [BIN_W-1:0]           snap_bin_reg;
    logic signed [AMP_W-1:0]    snap_amp_reg;

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [PROD_W-1:0] prod_reg;

    logic signed [SAMPLE_W:0] level, cur_x, prev_x, peak_x, cur_mag, peak_mag;
    logic signed [SAMPLE_W:0] peak_new_x, neg_peak, adc_x;
    logic signed [SAMPLE_W-1:0] peak_new;
    logic                     cross_now, bump, bigger;
    logic [BIN_W-1:0]         cross_val;
    logic [PER_W-1:0]         per_eff;
    logic [DEN_W:0]           rem_sh, rem_diff;
    logic                     qbit;
    logic [SUM_W-1:0]         code_sum;
    logic [CODE_W-1:0]        code_sat;
    logic signed [AMP_W-1:0]  amp_val;

    always_comb begin
        level    = -$signed({2'b00, thr_reg});
        cur_x    = $signed({s_sample[SAMPLE_W-1], s_sample});
        prev_x   = $signed({prev_reg[SAMPLE_W-1], prev_reg});
        peak_x   = $signed({peak_reg[SAMPLE_W-1], peak_reg});
        cross_now = (prev_x >= level) && (cur_x <= level);
        bump      = (cur_x == level) && (prev_x > level);
        cross_val = bin_reg + BIN_W'(bump);
        cur_mag   = (cur_x < 0) ? -cur_x : cur_x;
        peak_mag  = (peak_x < 0) ? -peak_x : peak_x;
        bigger    = $unsigned(cur_mag) > $unsigned(peak_mag);
        peak_new  = bigger ? s_sample : peak_reg;
        peak_new_x = $signed({peak_new[SAMPLE_W-1], peak_new});
        neg_peak  = -peak_new_x;
        adc_x     = $signed({2'b00, adc_reg});
        amp_val   = (neg_peak > adc_x) ? AMP_W'(adc_x) : neg_peak[AMP_W-1:0];
        status.crossing_any = seen_reg || cross_now;
    end

    assign per_eff  = (per_reg == '0) ? PER_W'(1) : per_reg;
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign qbit     = rem_sh >= {1'b0, den_reg};
    assign code_sum = SUM_W'(prod_reg) + SUM_W'(snap_bin_reg);
    assign code_sat = (code_sum > SUM_W'(TIME_CODE_MAX)) ? TIME_CODE_MAX
                                                         : code_sum[CODE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
            adc_reg <= ADC_RESET;
            per_reg <= PER_RESET;
            tdc_reg <= TDC_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                REG_ADC_LIMIT: adc_reg <= cfg_data[ADC_W-1:0];
                REG_PERIOD:    per_reg <= cfg_data[PER_W-1:0];
                REG_TDC:       tdc_reg <= cfg_data[TDC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            peak_reg      <= '0;
            bin_reg       <= '0;
            seen_reg      <= 1'b0;
            cross_bin_reg <= '0;
        end else if (cmd.sample_en) begin
            if (cross_now) begin
                cross_bin_reg <= cross_val;
            end
            if (s_last) begin
                prev_reg <= '0;
                peak_reg <= '0;
                bin_reg  <= '0;
                seen_reg <= 1'b0;
            end else begin
                prev_reg <= s_sample;
                peak_reg <= peak_new;
                seen_reg <= seen_reg || cross_now;
                if (bin_reg < BIN_HOLD) begin
                    bin_reg <= bin_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.snap_en) begin
            snap_cell_reg <= s_cell_id;
            snap_time_reg <= s_pulse_time_ps;
            snap_bin_reg  <= cross_now ? cross_val : cross_bin_reg;
            snap_amp_reg  <= amp_val;
        end
        if (cmd.mul_en) begin
            num_reg <= NUM_W'(snap_time_reg) * NUM_W'(PS_PER_NS) + NUM_W'(per_eff);
            den_reg <= DEN_W'(per_eff) * DEN_W'(PS_PER_NS);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= qbit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], qbit};
        end
        if (cmd.prod_en) begin
            prod_reg <= PROD_W'(num_reg[QUO_W-1:0]) * PROD_W'(tdc_reg);
        end
        if (cmd.out_load) begin
            m_hit_cell_id <= snap_cell_reg;
            m_amplitude   <= snap_amp_reg;
            m_time_code   <= code_sat;
        end
    end

endmodule

// File: design/ptpa_checker.sv
`include "pulse_threshold_tdc_peak_adc_defines.svh"

module ptpa_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [ptpa_pkg::CELL_W-1:0]       m_hit_cell_id,
    input logic signed [ptpa_pkg::AMP_W-1:0] m_amplitude,
    input logic [ptpa_pkg::CODE_W-1:0]       m_time_code
);
    import ptpa_pkg::*;

    `PTPA_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_time_code) && $stable(m_hit_cell_id) && $stable(m_amplitude), "result changed while stalled")
    `PTPA_ASSERT(a_code_sat, aclk, aresetn, m_valid |-> m_time_code != 31'h7FFFFFFF, "time code above saturation bound")
    `PTPA_ASSERT(a_amp_range, aclk, aresetn, m_valid |-> m_amplitude != 16'sh8000, "amplitude out of range")
    `PTPA_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind pulse_threshold_tdc_peak_adc ptpa_checker u_ptpa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_hit_cell_id (m_hit_cell_id),
    .m_amplitude   (m_amplitude),
    .m_time_code   (m_time_code)
);
